@@ hdl/sha256_message_hash_defines.svh @@
// ============================================================================
// SHA-256 message hash: assertion macros
// Concurrent assertion helpers for the top-level RTL file of the hash block.
// ============================================================================
`ifndef SHA256_MESSAGE_HASH_DEFINES_SVH
`define SHA256_MESSAGE_HASH_DEFINES_SVH

`ifndef SYNTH

// Implication checked in the same cycle.
`define SHA_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha256 check failed");

// Implication checked in the next cycle.
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 check failed");

`else

`define SHA_ASSERT(lbl, clk, rst_n, ante, cons)
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/sha_pkg.sv @@
// ============================================================================
// SHA-256 package
// Transfer types, sequencer states, datapath controls and hash constants.
// ============================================================================
package sha_pkg;

    localparam int CNT_W = 61;

    // One message byte transfer.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } sha_in_t;

    // One digest word transfer.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_HEAD,
        ST_PAD,
        ST_CMP_START,
        ST_ROUND_A,
        ST_ROUND_B,
        ST_FOLD,
        ST_EMIT
    } sha_state_t;

    // Controls from the sequencer to the round datapath.
    typedef struct packed {
        logic       load_work;
        logic       phase_a;
        logic       phase_b;
        logic       fold;
        logic       reinit;
        logic [5:0] rnd;
    } sha_ctrl_t;

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

@@ hdl/sha_wmem.sv @@
// ============================================================================
// SHA-256 schedule memory
// Sixteen 32-bit words holding the message block and the rolling schedule:
// one write port and two read ports with registered read data.
// ============================================================================
module sha_wmem (
    input  logic        clk,
    input  logic        we,
    input  logic [3:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [3:0]  raddr0,
    input  logic [3:0]  raddr1,
    output logic [31:0] rdata0,
    output logic [31:0] rdata1
);
    import sha_pkg::*;

    logic [31:0] mem_reg [16];
    logic [31:0] rdata0_reg;
    logic [31:0] rdata1_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read ports, with registered read data.
    always_ff @(posedge clk)
    begin
        rdata0_reg <= mem_reg[raddr0];
        rdata1_reg <= mem_reg[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

@@ hdl/sha_core.sv @@
// ============================================================================
// SHA-256 round datapath
// Working variables, chaining hash and the two-phase round arithmetic that
// consumes schedule words read from the schedule memory.
// ============================================================================
module sha_core (
    input  logic               clk,
    input  logic               rst_n,
    input  sha_pkg::sha_ctrl_t ctrl,
    input  logic [31:0]        rdata0,
    input  logic [31:0]        rdata1,
    input  logic [2:0]         emit_idx,
    output logic [31:0]        sched_word,
    output logic [31:0]        digest_word
);
    import sha_pkg::*;

    logic [31:0] hash_reg [8];
    logic [31:0] wv_reg [8];
    logic [31:0] sig_reg;
    logic [31:0] whold_reg;
    logic [31:0] hk_reg;

    logic        late_round;
    logic [31:0] w_cur;
    logic [31:0] t1;
    logic [31:0] t2;

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    // Rounds sixteen onwards extend the schedule.
    assign late_round = (ctrl.rnd[5:4] != 2'b00);

    // Second phase: finish the schedule word and run the round.
    always_comb
    begin
        w_cur = late_round ? (sig_reg + rdata0 + rdata1) : whold_reg;
        t1    = hk_reg + bsig1(wv_reg[4]) + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]))
                + w_cur;
        t2    = bsig0(wv_reg[0])
                + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
    end

    assign sched_word = w_cur;

    // Chaining hash: initial values, fold after each block, reload after a digest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= IV_TABLE[i];
            end
        end
        else if (ctrl.reinit)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= IV_TABLE[i];
            end
        end
        else if (ctrl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= hash_reg[i] + wv_reg[i];
            end
        end
    end

    // Working variables and the per-round staging registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_work)
        begin
            for (int i = 0; i < 8; i++)
            begin
                wv_reg[i] <= hash_reg[i];
            end
        end
        else if (ctrl.phase_a)
        begin
            if (late_round)
            begin
                sig_reg <= ssig1(rdata0) + ssig0(rdata1);
            end
            else
            begin
                whold_reg <= rdata0;
            end
            hk_reg <= wv_reg[7] + K_TABLE[ctrl.rnd];
        end
        else if (ctrl.phase_b)
        begin
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
    end

    assign digest_word = hash_reg[emit_idx];

endmodule

@@ hdl/sha256_message_hash.sv @@
// ============================================================================
// SHA-256 message hash
// Byte-wide SHA-256 engine: block assembly, padding, compression sequencing
// and digest output.
// ============================================================================
// Message bytes are taken one per transfer while the engine is idle. The
// byte that completes a 64-byte block starts a compression (one load step,
// 64 rounds of two phases each, one fold step), during which no byte is
// taken. Each round needs four schedule words and the schedule memory has
// two read ports, which is why each round has two phases. The final transfer
// adds one padding write for each word from the current word to the end of
// the block, sixteen more writes when the length needs a block of its own
// (also when the final byte fills its block exactly), and one compression
// for each padded block. Eight digest word transfers follow, word 0 first;
// the engine then returns to the initial hash values for the next message.
`include "sha256_message_hash_defines.svh"

module sha256_message_hash (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              msg_valid,
    output logic              msg_ready,
    input  sha_pkg::sha_in_t  msg,
    output logic              dig_valid,
    input  logic              dig_ready,
    output sha_pkg::sha_out_t dig
);
    import sha_pkg::*;

    sha_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [23:0]      asm_reg, asm_next;
    logic [5:0]       round_reg, round_next;
    logic [3:0]       pad_idx_reg, pad_idx_next;
    logic             end_pend_reg, end_pend_next;
    logic             pad_pend_reg, pad_pend_next;
    logic             extra_reg, extra_next;
    logic [2:0]       emit_idx_reg, emit_idx_next;

    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic [3:0]  mem_raddr0;
    logic [3:0]  mem_raddr1;
    logic [31:0] mem_rdata0;
    logic [31:0] mem_rdata1;

    sha_ctrl_t   ctrl;
    logic [31:0] sched_word;
    logic [31:0] digest_word;

    logic        dig_xfer;
    logic [1:0]  lane;
    logic [5:0]  next_round;
    logic [31:0] head_word;
    logic [31:0] len_hi;
    logic [31:0] len_lo;

    assign dig_xfer   = dig_valid && dig_ready;
    assign lane       = cnt_reg[1:0];
    assign next_round = round_reg + 6'd1;
    assign len_hi     = cnt_reg[CNT_W-1:CNT_W-32];
    assign len_lo     = {cnt_reg[CNT_W-33:0], 3'b000};

    // Final partial word: collected bytes, then the 0x80 marker, then zeros.
    always_comb
    begin
        case (lane)
            2'd0:    head_word = {8'h80, 24'd0};
            2'd1:    head_word = {asm_reg[23:16], 8'h80, 16'd0};
            2'd2:    head_word = {asm_reg[23:8], 8'h80, 8'd0};
            2'd3:    head_word = {asm_reg, 8'h80};
            default: head_word = '0;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            round_reg    <= '0;
            pad_idx_reg  <= '0;
            end_pend_reg <= 1'b0;
            pad_pend_reg <= 1'b0;
            extra_reg    <= 1'b0;
            emit_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            round_reg    <= round_next;
            pad_idx_reg  <= pad_idx_next;
            end_pend_reg <= end_pend_next;
            pad_pend_reg <= pad_pend_next;
            extra_reg    <= extra_next;
            emit_idx_reg <= emit_idx_next;
        end
    end

    // Byte assembly register holds the first three bytes of a word.
    always_ff @(posedge clk)
    begin
        asm_reg <= asm_next;
    end

    // Next state, memory port and datapath controls.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        asm_next      = asm_reg;
        round_next    = round_reg;
        pad_idx_next  = pad_idx_reg;
        end_pend_next = end_pend_reg;
        pad_pend_next = pad_pend_reg;
        extra_next    = extra_reg;
        emit_idx_next = emit_idx_reg;

        mem_we     = 1'b0;
        mem_waddr  = cnt_reg[5:2];
        mem_wdata  = sched_word;
        mem_raddr0 = round_reg[3:0];
        mem_raddr1 = round_reg[3:0];

        ctrl           = '0;
        ctrl.rnd       = round_reg;

        msg_ready = 1'b0;
        dig_valid = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                msg_ready = 1'b1;
                if (msg_valid)
                begin
                    if (msg.has_byte)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        case (lane)
                            2'd0:    asm_next[23:16] = msg.data_byte;
                            2'd1:    asm_next[15:8]  = msg.data_byte;
                            2'd2:    asm_next[7:0]   = msg.data_byte;
                            default:
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {asm_reg, msg.data_byte};
                            end
                        endcase
                        // A full block is compressed first; padding follows it.
                        if (cnt_reg[5:0] == 6'd63)
                        begin
                            pad_pend_next = msg.end_of_message;
                            state_next    = ST_CMP_START;
                        end
                        else if (msg.end_of_message)
                        begin
                            state_next = ST_PAD_HEAD;
                        end
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = ST_PAD_HEAD;
                    end
                end
            end

            ST_PAD_HEAD:
            begin
                mem_we        = 1'b1;
                mem_wdata     = head_word;
                end_pend_next = 1'b1;
                // No room for the length field: a further block follows.
                extra_next    = (cnt_reg[5:3] == 3'd7);
                if (cnt_reg[5:2] == 4'd15)
                begin
                    state_next = ST_CMP_START;
                end
                else
                begin
                    pad_idx_next = cnt_reg[5:2] + 4'd1;
                    state_next   = ST_PAD;
                end
            end

            ST_PAD:
            begin
                mem_we    = 1'b1;
                mem_waddr = pad_idx_reg;
                if (!extra_reg && pad_idx_reg == 4'd14)
                begin
                    mem_wdata = len_hi;
                end
                else if (!extra_reg && pad_idx_reg == 4'd15)
                begin
                    mem_wdata = len_lo;
                end
                else
                begin
                    mem_wdata = '0;
                end
                if (pad_idx_reg == 4'd15)
                begin
                    state_next = ST_CMP_START;
                end
                else
                begin
                    pad_idx_next = pad_idx_reg + 4'd1;
                end
            end

            ST_CMP_START:
            begin
                ctrl.load_work = 1'b1;
                mem_raddr0     = 4'd0;
                round_next     = '0;
                state_next     = ST_ROUND_A;
            end

            ST_ROUND_A:
            begin
                // Fetch w[t-7] and w[t-16] for the schedule extension.
                ctrl.phase_a = 1'b1;
                mem_raddr0   = round_reg[3:0] - 4'd7;
                mem_raddr1   = round_reg[3:0];
                state_next   = ST_ROUND_B;
            end

            ST_ROUND_B:
            begin
                ctrl.phase_b = 1'b1;
                mem_we       = (round_reg[5:4] != 2'b00);
                mem_waddr    = round_reg[3:0];
                mem_wdata    = sched_word;
                // Fetch for the next round: w[t-2] and w[t-15], or w[t] early on.
                if (next_round[5:4] != 2'b00)
                begin
                    mem_raddr0 = next_round[3:0] - 4'd2;
                end
                else
                begin
                    mem_raddr0 = next_round[3:0];
                end
                mem_raddr1 = next_round[3:0] + 4'd1;
                round_next = next_round;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_FOLD;
                end
                else
                begin
                    state_next = ST_ROUND_A;
                end
            end

            ST_FOLD:
            begin
                ctrl.fold = 1'b1;
                if (extra_reg)
                begin
                    extra_next   = 1'b0;
                    pad_idx_next = '0;
                    state_next   = ST_PAD;
                end
                else if (pad_pend_reg)
                begin
                    // The final byte filled the block: pad a fresh one.
                    pad_pend_next = 1'b0;
                    state_next    = ST_PAD_HEAD;
                end
                else if (end_pend_reg)
                begin
                    emit_idx_next = '0;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                dig_valid = 1'b1;
                if (dig_ready)
                begin
                    if (emit_idx_reg == 3'd7)
                    begin
                        ctrl.reinit   = 1'b1;
                        cnt_next      = '0;
                        end_pend_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Digest output transfer.
    always_comb
    begin
        dig.digest_word = digest_word;
        dig.word_index  = emit_idx_reg;
        dig.last_word   = (emit_idx_reg == 3'd7);
    end

    sha_wmem u_wmem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr0 (mem_raddr0),
        .raddr1 (mem_raddr1),
        .rdata0 (mem_rdata0),
        .rdata1 (mem_rdata1)
    );

    sha_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .rdata0      (mem_rdata0),
        .rdata1      (mem_rdata1),
        .emit_idx    (emit_idx_reg),
        .sched_word  (sched_word),
        .digest_word (digest_word)
    );

    // Checks on the sequencer.
    `SHA_ASSERT(a_no_msg_while_emit, clk, rst_n, dig_valid, !msg_ready)
    `SHA_ASSERT(a_idle_round_zero, clk, rst_n, state_reg == ST_IDLE, round_reg == 6'd0)
    `SHA_ASSERT(a_no_write_phase_a, clk, rst_n, state_reg == ST_ROUND_A, !mem_we)
    `SHA_ASSERT_NEXT(a_last_round_folds, clk, rst_n,
        state_reg == ST_ROUND_B && round_reg == 6'd63, state_reg == ST_FOLD)
    `SHA_ASSERT_NEXT(a_count_cleared, clk, rst_n, dig_xfer && dig.last_word, cnt_reg == '0)

endmodule
